// ----- rtl/icf_pkg.sv -----
// ----------------------------------------------------------------------------
// icf_pkg
// Shared types and constants of the image cell footprint block.
// ----------------------------------------------------------------------------
`default_nettype none

package icf_pkg;

  typedef enum logic [1:0] {
    UNIT_AUTO    = 2'd0,
    UNIT_CELLS   = 2'd1,
    UNIT_PIXELS  = 2'd2,
    UNIT_PERCENT = 2'd3
  } unit_t;

  localparam logic [1:0] CFG_CELL_W   = 2'd0;
  localparam logic [1:0] CFG_CELL_H   = 2'd1;
  localparam logic [1:0] CFG_SCREEN_C = 2'd2;
  localparam logic [1:0] CFG_SCREEN_R = 2'd3;

  localparam int CFG_WIDTH = 10;

  localparam logic [7:0] DEF_CELL_W  = 8'd8;
  localparam logic [7:0] DEF_CELL_H  = 8'd16;
  localparam logic [9:0] RST_SCREEN_C = 10'd80;
  localparam logic [9:0] RST_SCREEN_R = 10'd24;
  localparam logic [6:0] PCT_FULL    = 7'd100;

  typedef struct packed {
    logic [1:0]  width_unit;
    logic [15:0] width_amount;
    logic [1:0]  height_unit;
    logic [15:0] height_amount;
    logic        keep_aspect;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } in_t;

  typedef struct packed {
    logic [9:0] cell_cols;
    logic [9:0] cell_rows;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/icf_div.sv -----
// ----------------------------------------------------------------------------
// icf_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module icf_div #(
  parameter int NW = 16,
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [NW-1:0]      out_quo,
  output logic [SW-1:0]      out_side
);

  logic          vld_r  [NW];
  logic [DW-1:0] rem_r  [NW];
  logic [NW-1:0] num_r  [NW];
  logic [NW-1:0] quo_r  [NW];
  logic [DW-1:0] den_r  [NW];
  logic [SW-1:0] side_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          vld_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] num_in;
    logic [NW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign num_in  = in_num;
      assign quo_in  = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign num_in  = num_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      trial = {rem_in, num_in[NW-1]};
      diff  = trial - {1'b0, den_in};
      ge    = (trial >= {1'b0, den_in});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
      rem_r[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      num_r[k]  <= num_in << 1;
      quo_r[k]  <= {quo_in[NW-2:0], ge};
      den_r[k]  <= den_in;
      side_r[k] <= side_in;
    end
  end

  assign out_valid = vld_r[NW-1];
  assign out_quo   = quo_r[NW-1];
  assign out_side  = side_r[NW-1];

endmodule

`default_nettype wire

// ----- rtl/image_cell_footprint_core.sv -----
// ----------------------------------------------------------------------------
// image_cell_footprint_core
// Character-cell footprint of an inline image, fully pipelined.
//
//   channel  ports                          direction  transaction
//   input    start, busy, in_data           in         start & !busy
//   result   out_strobe, out_data           out        out_strobe, one cycle
//   config   cfg_we, cfg_index, cfg_wdata   in         cfg_we
//
// One transaction per cycle. Stages: capture, cell products, percent
// numerators, the three-stage reciprocal percent scaler, pixel resolve,
// cross products, the aspect divider (QW = 2*DIM_BITS+13 bits), the two
// ceiling dividers (columns, rows; CN = QW+1 bits) and the output register.
// busy is high only while reset is asserted. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module image_cell_footprint_core #(
  parameter int DIM_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire icf_pkg::in_t                  in_data,
  output logic                               out_strobe,
  output icf_pkg::out_t                      out_data,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [icf_pkg::CFG_WIDTH-1:0] cfg_wdata
);

  localparam int D  = DIM_BITS;
  localparam int PW = D + 12;
  localparam int PN = D + 18;
  localparam int QW = PW + D + 1;
  localparam int CN = QW + 1;

  // percent scaler: floor(x/100) = floor((x>>2) * RECIP / 2^RK)
  localparam int YW = PN - 2;
  localparam int RK = YW + 5;
  localparam int MW = YW + 1;
  localparam int YL = YW / 2;
  localparam int YH = YW - YL;
  localparam int ML = MW / 2;
  localparam int MH = MW - ML;
  localparam int RW = YW + MW;
  localparam logic [63:0] PCT_QTR = 64'(icf_pkg::PCT_FULL) >> 2;
  localparam logic [63:0] RECIP = ((64'd1 << RK) + PCT_QTR - 64'd1) / PCT_QTR;
  localparam logic [ML-1:0] RECIP_LO = RECIP[ML-1:0];
  localparam logic [MH-1:0] RECIP_HI = RECIP[MW-1:ML];

  typedef struct packed {
    icf_pkg::unit_t wu;
    icf_pkg::unit_t hu;
    logic           keep;
    logic [D-1:0]   wa;
    logic [D-1:0]   ha;
    logic [D-1:0]   iw;
    logic [D-1:0]   ih;
  } raw_t;

  typedef struct packed {
    raw_t           raw;
    logic [D+7:0]   wcell;
    logic [D+7:0]   hcell;
  } ctx_a_t;

  typedef struct packed {
    icf_pkg::unit_t wu;
    icf_pkg::unit_t hu;
    logic           keep;
    logic [D-1:0]   iw;
    logic [D-1:0]   ih;
    logic [PW-1:0]  tw;
    logic [PW-1:0]  th;
  } ctx_b_t;

  typedef struct packed {
    logic [PW-1:0]  tw;
    logic [PW-1:0]  th;
    logic           calc_w;
    logic           calc_h;
    logic           unknown;
  } ctx_c_t;

  // configuration
  logic [7:0] cell_width_r, cell_height_r;
  logic [9:0] screen_cols_r, screen_rows_r;
  logic [7:0] cw, ch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_width_r  <= icf_pkg::DEF_CELL_W;
      cell_height_r <= icf_pkg::DEF_CELL_H;
      screen_cols_r <= icf_pkg::RST_SCREEN_C;
      screen_rows_r <= icf_pkg::RST_SCREEN_R;
    end else if (cfg_we) begin
      unique case (cfg_index)
        icf_pkg::CFG_CELL_W:   cell_width_r  <= cfg_wdata[7:0];
        icf_pkg::CFG_CELL_H:   cell_height_r <= cfg_wdata[7:0];
        icf_pkg::CFG_SCREEN_C: screen_cols_r <= cfg_wdata[9:0];
        icf_pkg::CFG_SCREEN_R: screen_rows_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  assign cw   = (cell_width_r == 8'd0) ? icf_pkg::DEF_CELL_W : cell_width_r;
  assign ch   = (cell_height_r == 8'd0) ? icf_pkg::DEF_CELL_H : cell_height_r;
  assign busy = ~rst_n;

  // stage 1: capture
  logic v1_r;
  raw_t s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start & ~busy;
    end
    s1_r.wu   <= icf_pkg::unit_t'(in_data.width_unit);
    s1_r.hu   <= icf_pkg::unit_t'(in_data.height_unit);
    s1_r.keep <= in_data.keep_aspect;
    s1_r.wa   <= D'(in_data.width_amount);
    s1_r.ha   <= D'(in_data.height_amount);
    s1_r.iw   <= D'(in_data.image_width);
    s1_r.ih   <= D'(in_data.image_height);
  end

  // stage 2: cell products and percent scale
  logic   v2_r;
  ctx_a_t s2_r;
  logic [17:0] wk_r, hk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    s2_r.raw   <= s1_r;
    s2_r.wcell <= (D+8)'(s1_r.wa) * (D+8)'(cw);
    s2_r.hcell <= (D+8)'(s1_r.ha) * (D+8)'(ch);
    wk_r       <= 18'(screen_cols_r) * 18'(cw);
    hk_r       <= 18'(screen_rows_r) * 18'(ch);
  end

  // stage 3: percent numerators
  logic   v3_r;
  ctx_a_t s3_r;
  logic [PN-1:0] wpn_r, hpn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    s3_r  <= s2_r;
    wpn_r <= PN'(wk_r) * PN'(s2_r.raw.wa);
    hpn_r <= PN'(hk_r) * PN'(s2_r.raw.ha);
  end

  // percent division, lane 0 width, lane 1 height
  logic                    va1_r, va2_r, va3_r;
  ctx_a_t                  sa1_r, sa2_r, sa3_r;
  logic [1:0][YW-1:0]      py;
  logic [1:0][YL+ML-1:0]   pll_r;
  logic [1:0][YL+MH-1:0]   plh_r;
  logic [1:0][YH+ML-1:0]   phl_r;
  logic [1:0][YH+MH-1:0]   phh_r;
  logic [1:0][YL+MW-1:0]   plo_r;
  logic [1:0][YH+MW-1:0]   phi_r;
  logic [1:0][RW-1:0]      psum_r;
  logic          va_out;
  logic [PN-1:0] wpq, hpq;
  ctx_a_t        ca;

  assign py[0] = wpn_r[PN-1:2];
  assign py[1] = hpn_r[PN-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va1_r <= 1'b0;
      va2_r <= 1'b0;
      va3_r <= 1'b0;
    end else begin
      va1_r <= v3_r;
      va2_r <= va1_r;
      va3_r <= va2_r;
    end
    sa1_r <= s3_r;
    sa2_r <= sa1_r;
    sa3_r <= sa2_r;
    for (int j = 0; j < 2; j++) begin
      pll_r[j]  <= (YL+ML)'(py[j][YL-1:0]) * (YL+ML)'(RECIP_LO);
      plh_r[j]  <= (YL+MH)'(py[j][YL-1:0]) * (YL+MH)'(RECIP_HI);
      phl_r[j]  <= (YH+ML)'(py[j][YW-1:YL]) * (YH+ML)'(RECIP_LO);
      phh_r[j]  <= (YH+MH)'(py[j][YW-1:YL]) * (YH+MH)'(RECIP_HI);
      plo_r[j]  <= (YL+MW)'(pll_r[j]) + ((YL+MW)'(plh_r[j]) << ML);
      phi_r[j]  <= (YH+MW)'(phl_r[j]) + ((YH+MW)'(phh_r[j]) << ML);
      psum_r[j] <= RW'(plo_r[j]) + (RW'(phi_r[j]) << YL);
    end
  end

  assign va_out = va3_r;
  assign wpq    = PN'(psum_r[0][RW-1:RK]);
  assign hpq    = PN'(psum_r[1][RW-1:RK]);
  assign ca     = sa3_r;

  // stage 4: resolve to pixels
  logic [PW-1:0] tw_res, th_res;

  always_comb begin
    case (ca.raw.wu)
      icf_pkg::UNIT_AUTO:   tw_res = PW'(ca.raw.iw);
      icf_pkg::UNIT_CELLS:  tw_res = PW'(ca.wcell);
      icf_pkg::UNIT_PIXELS: tw_res = PW'(ca.raw.wa);
      default:              tw_res = PW'(wpq);
    endcase
    case (ca.raw.hu)
      icf_pkg::UNIT_AUTO:   th_res = PW'(ca.raw.ih);
      icf_pkg::UNIT_CELLS:  th_res = PW'(ca.hcell);
      icf_pkg::UNIT_PIXELS: th_res = PW'(ca.raw.ha);
      default:              th_res = PW'(hpq);
    endcase
  end

  logic   v4_r;
  ctx_b_t s4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= va_out;
    end
    s4_r.wu   <= ca.raw.wu;
    s4_r.hu   <= ca.raw.hu;
    s4_r.keep <= ca.raw.keep;
    s4_r.iw   <= ca.raw.iw;
    s4_r.ih   <= ca.raw.ih;
    s4_r.tw   <= tw_res;
    s4_r.th   <= th_res;
  end

  // stage 5: cross products
  logic   v5_r;
  ctx_b_t s5_r;
  logic [PW+D-1:0] p1_r, p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    s5_r <= s4_r;
    p1_r <= (PW+D)'(s4_r.iw) * (PW+D)'(s4_r.th);
    p2_r <= (PW+D)'(s4_r.tw) * (PW+D)'(s4_r.ih);
  end

  // aspect mode and rounding division setup
  logic          wauto, hauto, wider;
  ctx_c_t        c_in;
  logic [QW-1:0] b_num;
  logic [D:0]    b_den;

  always_comb begin
    wauto        = (s5_r.wu == icf_pkg::UNIT_AUTO);
    hauto        = (s5_r.hu == icf_pkg::UNIT_AUTO);
    wider        = (p1_r > p2_r);
    c_in.tw      = s5_r.tw;
    c_in.th      = s5_r.th;
    c_in.unknown = (s5_r.iw == '0) || (s5_r.ih == '0);
    c_in.calc_w  = s5_r.keep && ((wauto && !hauto) || (!wauto && !hauto && !wider));
    c_in.calc_h  = s5_r.keep && ((hauto && !wauto) || (!wauto && !hauto && wider));
    if (c_in.calc_w) begin
      b_num = {p1_r, 1'b0} + QW'(s5_r.ih);
      b_den = {s5_r.ih, 1'b0};
    end else begin
      b_num = {p2_r, 1'b0} + QW'(s5_r.iw);
      b_den = {s5_r.iw, 1'b0};
    end
  end

  logic          vb_out;
  logic [QW-1:0] bq;
  logic [$bits(ctx_c_t)-1:0] b_side;
  ctx_c_t        cb;

  icf_div #(.NW(QW), .DW(D+1), .SW($bits(ctx_c_t))) u_div_asp (
    .clk(clk), .rst_n(rst_n),
    .in_valid(v5_r), .in_num(b_num), .in_den(b_den), .in_side(c_in),
    .out_valid(vb_out), .out_quo(bq), .out_side(b_side)
  );

  assign cb = ctx_c_t'(b_side);

  // ceiling division setup
  logic [QW-1:0] w_px, h_px;
  logic [CN-1:0] cnum_w, cnum_h;

  always_comb begin
    w_px   = cb.calc_w ? bq : QW'(cb.tw);
    h_px   = cb.calc_h ? bq : QW'(cb.th);
    cnum_w = CN'(w_px) + CN'(cw) - CN'(1);
    cnum_h = CN'(h_px) + CN'(ch) - CN'(1);
  end

  logic          vc_out, unk_c, unused_c;
  logic [CN-1:0] qc, qr;

  icf_div #(.NW(CN), .DW(8), .SW(1)) u_div_cols (
    .clk(clk), .rst_n(rst_n),
    .in_valid(vb_out), .in_num(cnum_w), .in_den(cw), .in_side(cb.unknown),
    .out_valid(vc_out), .out_quo(qc), .out_side(unk_c)
  );

  icf_div #(.NW(CN), .DW(8), .SW(1)) u_div_rows (
    .clk(clk), .rst_n(rst_n),
    .in_valid(vb_out), .in_num(cnum_h), .in_den(ch), .in_side(1'b0),
    .out_valid(), .out_quo(qr), .out_side(unused_c)
  );

  // final clamp
  logic [CN-1:0] nc, nr;
  icf_pkg::out_t res_nxt;
  icf_pkg::out_t out_data_r;
  logic          out_strobe_r;

  always_comb begin
    nc = (qc == '0) ? CN'(1) : qc;
    nr = (qr == '0) ? CN'(1) : qr;
    if (nc > CN'(screen_cols_r)) nc = CN'(screen_cols_r);
    if (nr > CN'(screen_rows_r)) nr = CN'(screen_rows_r);
    if (unk_c) begin
      res_nxt.cell_cols = 10'd1;
      res_nxt.cell_rows = 10'd1 | {9'd0, unused_c};
    end else begin
      res_nxt.cell_cols = nc[9:0];
      res_nxt.cell_rows = nr[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vc_out;
    end
    out_data_r <= res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  a_cols_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && screen_cols_r != 10'd0) |-> out_data.cell_cols != 10'd0)
    else $error("zero columns with nonzero screen");

  a_rows_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && screen_rows_r != 10'd0) |-> out_data.cell_rows != 10'd0)
    else $error("zero rows with nonzero screen");

  a_clamp : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.cell_cols > screen_cols_r) |->
      (out_data.cell_cols == 10'd1 && out_data.cell_rows == 10'd1))
    else $error("columns exceed screen outside unknown-size case");

endmodule

`default_nettype wire

// ----- tb/image_cell_footprint_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// image_cell_footprint_core_tb
// Self-checking bench for the image cell footprint core. A queue-fed driver
// issues sizing requests with random gaps. A footprint predictor computes the
// expected cell columns and rows when each transaction is accepted. The
// monitor checks every strobed result against the oldest prediction. The run
// steps through several cell and screen settings, extremes included.
// ----------------------------------------------------------------------------
`default_nettype none

module image_cell_footprint_core_tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 160;

  typedef struct {
    icf_pkg::in_t item;
    int           gap;
  } req_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  icf_pkg::in_t                  in_data = '0;
  logic                          out_strobe;
  icf_pkg::out_t                 out_data;
  logic                          cfg_we = 1'b0;
  logic [1:0]                    cfg_index = icf_pkg::CFG_CELL_W;
  logic [icf_pkg::CFG_WIDTH-1:0] cfg_wdata = '0;

  image_cell_footprint_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model copy of the configuration registers
  logic [7:0] m_cell_w = icf_pkg::DEF_CELL_W;
  logic [7:0] m_cell_h = icf_pkg::DEF_CELL_H;
  logic [9:0] m_scr_c = icf_pkg::RST_SCREEN_C;
  logic [9:0] m_scr_r = icf_pkg::RST_SCREEN_R;

  req_t          pending_reqs[$];
  icf_pkg::out_t expected_sizes[$];
  int   errors = 0;
  int   cycles = 0;
  int   gap_left = 0;
  bit   gap_drawn = 0;
  bit   took = 0;
  bit   bursty = 0;

  function automatic longint unsigned side_pixels(icf_pkg::unit_t u,
      longint unsigned amt, longint unsigned cell_px, longint unsigned scr,
      longint unsigned nat);
    case (u)
      icf_pkg::UNIT_AUTO:   return nat;
      icf_pkg::UNIT_CELLS:  return amt * cell_px;
      icf_pkg::UNIT_PIXELS: return amt;
      default:              return (scr * cell_px * amt) / icf_pkg::PCT_FULL;
    endcase
  endfunction

  function automatic longint unsigned round_scale(longint unsigned a,
      longint unsigned b, longint unsigned c);
    return (2 * a * b + c) / (2 * c);
  endfunction

  function automatic longint unsigned pixels_to_cells(longint unsigned px,
      longint unsigned cell_px, longint unsigned scr);
    longint unsigned n;
    n = (px + cell_px - 1) / cell_px;
    if (n < 1) n = 1;
    if (n > scr) n = scr;
    return n;
  endfunction

  function automatic icf_pkg::out_t footprint_of(icf_pkg::in_t d);
    longint unsigned cw, ch, iw, ih, tw, th;
    icf_pkg::unit_t wu, hu;
    icf_pkg::out_t r;
    wu = icf_pkg::unit_t'(d.width_unit);
    hu = icf_pkg::unit_t'(d.height_unit);
    iw = d.image_width;
    ih = d.image_height;
    cw = (m_cell_w == 0) ? icf_pkg::DEF_CELL_W : m_cell_w;
    ch = (m_cell_h == 0) ? icf_pkg::DEF_CELL_H : m_cell_h;
    if (iw == 0 || ih == 0) begin
      r.cell_cols = 10'd1;
      r.cell_rows = 10'd1;
      return r;
    end
    tw = side_pixels(wu, d.width_amount, cw, m_scr_c, iw);
    th = side_pixels(hu, d.height_amount, ch, m_scr_r, ih);
    if (d.keep_aspect) begin
      if (wu == icf_pkg::UNIT_AUTO && hu == icf_pkg::UNIT_AUTO) begin
        tw = iw;
        th = ih;
      end else if (wu == icf_pkg::UNIT_AUTO) begin
        tw = round_scale(th, iw, ih);
      end else if (hu == icf_pkg::UNIT_AUTO) begin
        th = round_scale(tw, ih, iw);
      end else if (iw * th > tw * ih) begin
        th = round_scale(tw, ih, iw);
      end else begin
        tw = round_scale(th, iw, ih);
      end
    end
    r.cell_cols = 10'(pixels_to_cells(tw, cw, m_scr_c));
    r.cell_rows = 10'(pixels_to_cells(th, ch, m_scr_r));
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // acceptance, prediction and result checking
  always @(posedge clk) begin
    icf_pkg::out_t want;
    cycles++;
    took <= start && !busy;
    if (rst_n && start && !busy) expected_sizes.push_back(footprint_of(in_data));
    if (rst_n && out_strobe) begin
      if (expected_sizes.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_sizes.pop_front();
        if (out_data.cell_cols !== want.cell_cols)
          report_mismatch("cell_cols", out_data.cell_cols, want.cell_cols);
        if (out_data.cell_rows !== want.cell_rows)
          report_mismatch("cell_rows", out_data.cell_rows, want.cell_rows);
      end
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // request driver
  always @(negedge clk) begin
    logic         nxt_start;
    icf_pkg::in_t nxt_data;
    req_t         r;
    nxt_start = start;
    nxt_data = in_data;
    if (rst_n && !(start && !took)) begin
      nxt_start = 1'b0;
      if (pending_reqs.size() != 0) begin
        if (!gap_drawn) begin
          gap_left = pending_reqs[0].gap;
          gap_drawn = 1;
        end
        if (gap_left == 0) begin
          r = pending_reqs.pop_front();
          nxt_start = 1'b1;
          nxt_data = r.item;
          gap_drawn = 0;
        end else begin
          gap_left--;
        end
      end
    end
    start <= nxt_start;
    in_data <= nxt_data;
  end

  task automatic queue_req(icf_pkg::in_t d);
    req_t r;
    r.item = d;
    r.gap = bursty ? 0 : $urandom_range(0, 4);
    pending_reqs.push_back(r);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= icf_pkg::CFG_WIDTH'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      icf_pkg::CFG_CELL_W:   m_cell_w = 8'(val);
      icf_pkg::CFG_CELL_H:   m_cell_h = 8'(val);
      icf_pkg::CFG_SCREEN_C: m_scr_c = 10'(val);
      default:               m_scr_r = 10'(val);
    endcase
  endtask

  task automatic set_geometry(int cw, int ch, int sc, int sr);
    write_reg(icf_pkg::CFG_CELL_W, cw);
    write_reg(icf_pkg::CFG_CELL_H, ch);
    write_reg(icf_pkg::CFG_SCREEN_C, sc);
    write_reg(icf_pkg::CFG_SCREEN_R, sr);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || start || expected_sizes.size() != 0);
  endtask

  function automatic logic [15:0] rand_amount();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 20));
      1: return 16'($urandom_range(0, 400));
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      3: return 16'($urandom_range(90, 110));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic icf_pkg::in_t make_req(icf_pkg::unit_t wu, logic [15:0] wa,
      icf_pkg::unit_t hu, logic [15:0] ha, logic keep, logic [15:0] iw,
      logic [15:0] ih);
    icf_pkg::in_t d;
    d.width_unit = wu;
    d.width_amount = wa;
    d.height_unit = hu;
    d.height_amount = ha;
    d.keep_aspect = keep;
    d.image_width = iw;
    d.image_height = ih;
    return d;
  endfunction

  task automatic random_phase(int n);
    icf_pkg::in_t d;
    bursty = 0;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) bursty = ($urandom_range(0, 2) == 0);
      d = make_req(icf_pkg::unit_t'($urandom_range(0, 3)), rand_amount(),
                   icf_pkg::unit_t'($urandom_range(0, 3)), rand_amount(),
                   1'($urandom_range(0, 1)),
                   ($urandom_range(0, 15) == 0) ? 16'h0000 : rand_amount(),
                   ($urandom_range(0, 15) == 0) ? 16'h0000 : rand_amount());
      if (d.image_width == 0 && $urandom_range(0, 3) != 0) d.image_width = 16'd1;
      if (d.image_height == 0 && $urandom_range(0, 3) != 0) d.image_height = 16'd1;
      queue_req(d);
    end
    wait_idle();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed requests at reset geometry
    queue_req(make_req(icf_pkg::UNIT_AUTO, 0, icf_pkg::UNIT_AUTO, 0, 0, 0, 100));
    queue_req(make_req(icf_pkg::UNIT_AUTO, 0, icf_pkg::UNIT_AUTO, 0, 1, 100, 0));
    queue_req(make_req(icf_pkg::UNIT_AUTO, 0, icf_pkg::UNIT_AUTO, 0, 0, 640, 480));
    queue_req(make_req(icf_pkg::UNIT_AUTO, 0, icf_pkg::UNIT_AUTO, 0, 1,
                       16'hFFFF, 16'hFFFF));
    queue_req(make_req(icf_pkg::UNIT_CELLS, 10, icf_pkg::UNIT_CELLS, 5, 0, 640, 480));
    queue_req(make_req(icf_pkg::UNIT_PIXELS, 100, icf_pkg::UNIT_PIXELS, 50, 0,
                       640, 480));
    queue_req(make_req(icf_pkg::UNIT_PERCENT, 50, icf_pkg::UNIT_PERCENT, 100, 0,
                       640, 480));
    queue_req(make_req(icf_pkg::UNIT_AUTO, 0, icf_pkg::UNIT_CELLS, 4, 1, 640, 480));
    queue_req(make_req(icf_pkg::UNIT_PIXELS, 333, icf_pkg::UNIT_AUTO, 0, 1, 640, 480));
    queue_req(make_req(icf_pkg::UNIT_PERCENT, 100, icf_pkg::UNIT_AUTO, 0, 1, 3, 2));
    queue_req(make_req(icf_pkg::UNIT_CELLS, 20, icf_pkg::UNIT_CELLS, 20, 1, 640, 480));
    queue_req(make_req(icf_pkg::UNIT_CELLS, 20, icf_pkg::UNIT_CELLS, 2, 1, 640, 480));
    queue_req(make_req(icf_pkg::UNIT_PIXELS, 0, icf_pkg::UNIT_PIXELS, 0, 1, 640, 480));
    queue_req(make_req(icf_pkg::UNIT_PIXELS, 0, icf_pkg::UNIT_PIXELS, 50, 1,
                       640, 480));
    queue_req(make_req(icf_pkg::UNIT_PIXELS, 50, icf_pkg::UNIT_PIXELS, 0, 1,
                       640, 480));
    queue_req(make_req(icf_pkg::UNIT_PIXELS, 16'hFFFF, icf_pkg::UNIT_PIXELS,
                       16'hFFFF, 1, 1, 16'hFFFF));
    queue_req(make_req(icf_pkg::UNIT_CELLS, 16'hFFFF, icf_pkg::UNIT_PERCENT,
                       16'hFFFF, 0, 1, 1));
    queue_req(make_req(icf_pkg::UNIT_PERCENT, 16'hFFFF, icf_pkg::UNIT_CELLS,
                       16'hFFFF, 1, 16'hFFFF, 1));
    queue_req(make_req(icf_pkg::UNIT_AUTO, 0, icf_pkg::UNIT_PIXELS, 3, 1, 3, 2));
    queue_req(make_req(icf_pkg::UNIT_PIXELS, 1, icf_pkg::UNIT_AUTO, 0, 1, 2, 3));
    wait_idle();

    random_phase(300);
    set_geometry(0, 0, 0, 0);
    queue_req(make_req(icf_pkg::UNIT_PIXELS, 100, icf_pkg::UNIT_PIXELS, 100, 0,
                       640, 480));
    queue_req(make_req(icf_pkg::UNIT_AUTO, 0, icf_pkg::UNIT_AUTO, 0, 0, 0, 5));
    random_phase(150);
    set_geometry(255, 255, 1023, 1023);
    random_phase(250);
    set_geometry(1, 1, 1, 1);
    random_phase(150);
    set_geometry(1, 1, 1023, 1023);
    random_phase(200);
    set_geometry(7, 13, 200, 60);
    random_phase(200);
    set_geometry($urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 1023), $urandom_range(0, 1023));
    random_phase(200);
    set_geometry(8, 16, 80, 24);
    random_phase(150);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && expected_sizes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
